/* rtl/mkdlp_pkg.sv */
// ----------------------------------------------------------------------------
// mkdlp_pkg
// Shared types and constants for the multi-key debounce and long-press unit.
// ----------------------------------------------------------------------------
package mkdlp_pkg;

	localparam int KEY_COUNT_DEF = 4;
	localparam int LEVEL_W       = 4;
	localparam int KEY_W         = 2;
	localparam int DEB_W         = 8;
	localparam int CNT_W         = 16;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 16;

	localparam logic [DEB_W-1:0] DEB_RESET  = 8'd1;
	localparam logic [CNT_W-1:0] LONG_RESET = 16'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE = 1'b0,
		REG_LONG     = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		MODE_TICK = 1'b0,
		MODE_TAKE = 1'b1
	} mode_t;

	typedef enum logic [3:0] {
		PH_RELEASED = 4'b0001,
		PH_DEBOUNCE = 4'b0010,
		PH_PRESSED  = 4'b0100,
		PH_LONG     = 4'b1000
	} phase_t;

	// command broadcast to every cell
	typedef struct packed {
		logic tick;
		logic take;
	} cmd_t;

	// priority chain passed from a cell to its higher-index neighbour
	typedef struct packed {
		logic long_seen;
		logic short_seen;
	} chain_t;

endpackage

/* rtl/mkdlp_if.sv */
// ----------------------------------------------------------------------------
// mkdlp_if
// Valid/ready channels of the multi-key debounce and long-press unit.
// ----------------------------------------------------------------------------
interface mkdlp_req_if;
	logic                             valid;
	logic                             ready;
	logic                             mode;
	logic [mkdlp_pkg::LEVEL_W-1:0]    key_levels;

	modport source (output valid, mode, key_levels, input ready);
	modport sink   (input valid, mode, key_levels, output ready);
endinterface

interface mkdlp_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           event_valid;
	logic [mkdlp_pkg::KEY_W-1:0]    event_key;
	logic                           event_long;

	modport source (output valid, event_valid, event_key, event_long, input ready);
	modport sink   (input valid, event_valid, event_key, event_long, output ready);
endinterface

interface mkdlp_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [mkdlp_pkg::CFG_IDX_W-1:0]    index;
	logic [mkdlp_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/mkdlp_key_cell.sv */
// ----------------------------------------------------------------------------
// mkdlp_key_cell
// One key: phase machine, hold counter, pending event flags and its link in
// the take priority chain.
// ----------------------------------------------------------------------------
module mkdlp_key_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mkdlp_pkg::cmd_t                 cmd,
	input  logic                            down,
	input  logic [mkdlp_pkg::DEB_W-1:0]     debounce_ticks,
	input  logic [mkdlp_pkg::CNT_W-1:0]     long_ticks,
	input  logic                            any_long,
	input  mkdlp_pkg::chain_t               chain_i,
	output mkdlp_pkg::chain_t               chain_o,
	output logic                            grant_long,
	output logic                            grant_short
);

	mkdlp_pkg::phase_t               phase_q, phase_d;
	logic [mkdlp_pkg::CNT_W-1:0]     cnt_q, cnt_d;
	logic [mkdlp_pkg::CNT_W-1:0]     cnt_inc;
	logic                            long_q, long_d;
	logic                            short_q, short_d;

	assign cnt_inc = mkdlp_pkg::CNT_W'({1'b0, cnt_q} + 17'd1);

	assign chain_o.long_seen  = chain_i.long_seen | long_q;
	assign chain_o.short_seen = chain_i.short_seen | short_q;
	assign grant_long  = cmd.take & long_q & ~chain_i.long_seen;
	assign grant_short = cmd.take & short_q & ~chain_i.short_seen & ~any_long;

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		long_d  = long_q & ~grant_long;
		short_d = short_q & ~grant_short;
		if (cmd.tick) begin
			unique case (phase_q)
				mkdlp_pkg::PH_RELEASED: begin
					if (down) begin
						phase_d = mkdlp_pkg::PH_DEBOUNCE;
						cnt_d   = '0;
					end
				end
				mkdlp_pkg::PH_DEBOUNCE: begin
					if (!down) begin
						phase_d = mkdlp_pkg::PH_RELEASED;
					end else if (cnt_inc >= {8'd0, debounce_ticks}) begin
						phase_d = mkdlp_pkg::PH_PRESSED;
						cnt_d   = '0;
					end else begin
						cnt_d = cnt_inc;
					end
				end
				mkdlp_pkg::PH_PRESSED: begin
					if (!down) begin
						short_d = 1'b1;
						phase_d = mkdlp_pkg::PH_RELEASED;
					end else begin
						cnt_d = cnt_inc;
						if (cnt_inc >= long_ticks) begin
							phase_d = mkdlp_pkg::PH_LONG;
						end
					end
				end
				mkdlp_pkg::PH_LONG: begin
					if (!down) begin
						long_d  = 1'b1;
						phase_d = mkdlp_pkg::PH_RELEASED;
					end
				end
				default: begin
					phase_d = mkdlp_pkg::PH_RELEASED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mkdlp_pkg::PH_RELEASED;
			cnt_q   <= '0;
			long_q  <= 1'b0;
			short_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			long_q  <= long_d;
			short_q <= short_d;
		end
	end

endmodule

/* rtl/multi_key_debounce_long_press_unit.sv */
// ----------------------------------------------------------------------------
// multi_key_debounce_long_press_unit
// Debounce and short/long press detection for a row of active-low keys.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per handshake: mode 0 samples key_levels once and
//   advances every key, mode 1 takes the highest-ranked pending event (long
//   before short, lower key first).
//   rsp returns exactly one item per request item: event_valid, event_key and
//   event_long, all zero for a tick or for a take that found nothing.
//   cfg writes debounce_ticks (index 0) or long_ticks (index 1); it is always
//   ready and should only be used while the unit is idle.
//   The single output register after the key cells holds the response,
//   valid the cycle after accept; one item per cycle while rsp is ready.
//   When rsp stalls, req is held off only while the output register is full
//   and not being emptied in the same cycle.
//   Reset puts every key in the released phase with no pending events and
//   loads debounce_ticks = 1 and long_ticks = 100.
// ----------------------------------------------------------------------------
module multi_key_debounce_long_press_unit #(
	parameter int KEY_COUNT = mkdlp_pkg::KEY_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mkdlp_req_if.sink req,
	mkdlp_rsp_if.source rsp,
	mkdlp_cfg_if.sink cfg
);

	logic [mkdlp_pkg::DEB_W-1:0]  debounce_ticks_q;
	logic [mkdlp_pkg::CNT_W-1:0]  long_ticks_q;

	logic                         vld_q;
	logic                         ev_valid_q;
	logic [mkdlp_pkg::KEY_W-1:0]  ev_key_q;
	logic                         ev_long_q;

	logic                         accept;
	mkdlp_pkg::cmd_t              cmd;
	mkdlp_pkg::chain_t            chain [KEY_COUNT+1];
	logic [KEY_COUNT-1:0]         down;
	logic [KEY_COUNT-1:0]         grant_long;
	logic [KEY_COUNT-1:0]         grant_short;
	logic [mkdlp_pkg::KEY_W-1:0]  key_sel;

	assign cfg.ready = 1'b1;
	assign req.ready = ~vld_q | rsp.ready;
	assign accept    = req.valid & req.ready;

	assign cmd.tick = accept & (req.mode == mkdlp_pkg::MODE_TICK);
	assign cmd.take = accept & (req.mode == mkdlp_pkg::MODE_TAKE);

	assign chain[0] = '0;

	for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
		if (k < mkdlp_pkg::LEVEL_W) begin : g_pin
			assign down[k] = ~req.key_levels[k];
		end else begin : g_nopin
			assign down[k] = 1'b0;
		end

		mkdlp_key_cell u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.cmd            (cmd),
			.down           (down[k]),
			.debounce_ticks (debounce_ticks_q),
			.long_ticks     (long_ticks_q),
			.any_long       (chain[KEY_COUNT].long_seen),
			.chain_i        (chain[k]),
			.chain_o        (chain[k+1]),
			.grant_long     (grant_long[k]),
			.grant_short    (grant_short[k])
		);
	end

	always_comb begin
		key_sel = '0;
		for (int k = 0; k < KEY_COUNT; k++) begin
			if (grant_long[k] | grant_short[k]) begin
				key_sel = key_sel | mkdlp_pkg::KEY_W'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= mkdlp_pkg::DEB_RESET;
			long_ticks_q     <= mkdlp_pkg::LONG_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				mkdlp_pkg::REG_DEBOUNCE: debounce_ticks_q <= cfg.data[mkdlp_pkg::DEB_W-1:0];
				mkdlp_pkg::REG_LONG:     long_ticks_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (req.ready) begin
			vld_q <= accept;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ev_valid_q <= |(grant_long | grant_short);
			ev_key_q   <= key_sel;
			ev_long_q  <= |grant_long;
		end
	end

	assign rsp.valid       = vld_q;
	assign rsp.event_valid = ev_valid_q;
	assign rsp.event_key   = ev_key_q;
	assign rsp.event_long  = ev_long_q;

`ifndef ASSERT_OFF
	a_grant_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({grant_long, grant_short}))
		else $error("more than one event granted");

	a_tick_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick |=> (rsp.valid && !rsp.event_valid))
		else $error("tick item reported an event");

	a_grant_only_take: assert property (@(posedge clk) disable iff (!arst_n)
		(|(grant_long | grant_short)) |-> cmd.take)
		else $error("event granted without a take item");

	a_take_reports: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && (|grant_long)) |=> (rsp.event_valid && rsp.event_long))
		else $error("granted long event not reported");
`endif

endmodule

/* bench/tb_multi_key_debounce_long_press_unit.sv */
// ----------------------------------------------------------------------------
// tb_multi_key_debounce_long_press_unit
// Self-checking bench for the four-key debounce and long-press unit. A
// directed table covers reset behaviour, short and long presses, merged
// events, event ranking and zero and maximum register values. It is followed
// by random key press patterns under several register settings. Every
// response is checked against a cycle-free model of the key machines or a
// directed row's fixed report, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_multi_key_debounce_long_press_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEYS        = mkdlp_pkg::KEY_COUNT_DEF;
	localparam int CYCLE_LIMIT = 500000;
	localparam int N_ROWS      = 33;
	localparam int N_PHASES    = 6;

	typedef struct packed {
		logic                        found;
		logic [mkdlp_pkg::KEY_W-1:0] key;
		logic                        is_long;
	} report_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t                        kind;
		mkdlp_pkg::mode_t                 mode;
		logic [mkdlp_pkg::LEVEL_W-1:0]    levels;
		logic                             typed;
		report_t                          want;
		mkdlp_pkg::cfg_reg_t              cfg_sel;
		logic [mkdlp_pkg::CFG_DATA_W-1:0] data;
	} row_t;

	localparam report_t NO_EVENT = '0;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	mkdlp_req_if req_ch ();
	mkdlp_rsp_if rsp_ch ();
	mkdlp_cfg_if cfg_ch ();

	multi_key_debounce_long_press_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always #6 clk = ~clk;

	// key machine state
	mkdlp_pkg::phase_t           stage [KEYS] = '{default: mkdlp_pkg::PH_RELEASED};
	logic [mkdlp_pkg::CNT_W-1:0] held [KEYS]  = '{default: '0};
	logic                        short_seen [KEYS] = '{default: 1'b0};
	logic                        long_seen [KEYS]  = '{default: 1'b0};
	logic [mkdlp_pkg::DEB_W-1:0] deb_limit  = mkdlp_pkg::DEB_RESET;
	logic [mkdlp_pkg::CNT_W-1:0] long_limit = mkdlp_pkg::LONG_RESET;

	report_t awaited_events [$];
	int      faults    = 0;
	int      delivered = 0;
	int      cycles    = 0;
	int      send_calm = 0;
	int      recv_calm = 0;
	bit      squeezed  = 1'b0;

	row_t directed [N_ROWS] = '{
		'{ROW_ITEM, mkdlp_pkg::MODE_TAKE, 4'hF, 1'b1, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TICK, 4'hF, 1'b1, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TICK, 4'h0, 1'b1, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TICK, 4'h0, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TICK, 4'hF, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TAKE, 4'h0, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TAKE, 4'h5, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TAKE, 4'hA, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TAKE, 4'hF, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TAKE, 4'h0, 1'b1, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		// same key pressed twice before a take merges into one event
		'{ROW_ITEM, mkdlp_pkg::MODE_TICK, 4'hE, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TICK, 4'hE, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TICK, 4'hF, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TICK, 4'hE, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TICK, 4'hE, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TICK, 4'hF, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TAKE, 4'hF, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TAKE, 4'hF, 1'b1, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		// zero limits, long event on back outranks short event on up
		'{ROW_CFG,  mkdlp_pkg::MODE_TICK, 4'hF, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_CFG,  mkdlp_pkg::MODE_TICK, 4'hF, 1'b0, NO_EVENT, mkdlp_pkg::REG_LONG,     16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TICK, 4'h6, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TICK, 4'h6, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TICK, 4'h7, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TICK, 4'hF, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TAKE, 4'h3, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TAKE, 4'hC, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TAKE, 4'hF, 1'b1, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		// maximum limits, a bounce never confirms
		'{ROW_CFG,  mkdlp_pkg::MODE_TICK, 4'hF, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd255},
		'{ROW_CFG,  mkdlp_pkg::MODE_TICK, 4'hF, 1'b0, NO_EVENT, mkdlp_pkg::REG_LONG,   16'd65535},
		'{ROW_ITEM, mkdlp_pkg::MODE_TICK, 4'h0, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TICK, 4'h5, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TICK, 4'hF, 1'b0, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0},
		'{ROW_ITEM, mkdlp_pkg::MODE_TAKE, 4'hF, 1'b1, NO_EVENT, mkdlp_pkg::REG_DEBOUNCE, 16'd0}
	};

	int unsigned phase_deb   [N_PHASES] = '{1, 2, 0, 6, 255, 1};
	int unsigned phase_long  [N_PHASES] = '{1, 5, 0, 40, 65535, 100};
	int unsigned phase_items [N_PHASES] = '{200, 200, 150, 200, 350, 200};

	function automatic report_t step_keys(mkdlp_pkg::mode_t m,
			logic [mkdlp_pkg::LEVEL_W-1:0] lv);
		report_t r;
		bit      down;
		bit      done;
		int      k;
		r    = NO_EVENT;
		done = 1'b0;
		if (m == mkdlp_pkg::MODE_TICK) begin
			for (k = 0; k < KEYS; k++) begin
				down = !lv[k];
				case (stage[k])
					mkdlp_pkg::PH_RELEASED: begin
						if (down) begin
							stage[k] = mkdlp_pkg::PH_DEBOUNCE;
							held[k]  = '0;
						end
					end
					mkdlp_pkg::PH_DEBOUNCE: begin
						if (!down) begin
							stage[k] = mkdlp_pkg::PH_RELEASED;
						end else begin
							held[k] = held[k] + 1'b1;
							if (held[k] >= {8'd0, deb_limit}) begin
								stage[k] = mkdlp_pkg::PH_PRESSED;
								held[k]  = '0;
							end
						end
					end
					mkdlp_pkg::PH_PRESSED: begin
						if (!down) begin
							short_seen[k] = 1'b1;
							stage[k]      = mkdlp_pkg::PH_RELEASED;
						end else begin
							held[k] = held[k] + 1'b1;
							if (held[k] >= long_limit)
								stage[k] = mkdlp_pkg::PH_LONG;
						end
					end
					default: begin
						if (!down) begin
							long_seen[k] = 1'b1;
							stage[k]     = mkdlp_pkg::PH_RELEASED;
						end
					end
				endcase
			end
		end else begin
			for (k = 0; k < KEYS; k++) begin
				if (!done && long_seen[k]) begin
					long_seen[k] = 1'b0;
					r            = '{1'b1, mkdlp_pkg::KEY_W'(k), 1'b1};
					done         = 1'b1;
				end
			end
			for (k = 0; k < KEYS; k++) begin
				if (!done && short_seen[k]) begin
					short_seen[k] = 1'b0;
					r             = '{1'b1, mkdlp_pkg::KEY_W'(k), 1'b0};
					done          = 1'b1;
				end
			end
		end
		return r;
	endfunction

	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = 40;
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	task automatic offer_item(mkdlp_pkg::mode_t m, logic [mkdlp_pkg::LEVEL_W-1:0] lv,
			logic typed, report_t want);
		int      gap;
		report_t predicted;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.mode       <= m;
		req_ch.key_levels <= lv;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
		predicted = step_keys(m, lv);
		awaited_events.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	task automatic write_reg(mkdlp_pkg::cfg_reg_t sel,
			logic [mkdlp_pkg::CFG_DATA_W-1:0] value);
		req_ch.valid <= 1'b0;
		while (awaited_events.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= sel;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		if (sel == mkdlp_pkg::REG_DEBOUNCE)
			deb_limit = value[mkdlp_pkg::DEB_W-1:0];
		else
			long_limit = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// stimulus
	initial begin
		int unsigned                   p;
		int unsigned                   n;
		int unsigned                   run;
		int unsigned                   pick;
		int                            i;
		int                            k;
		bit                            pressed [KEYS];
		int unsigned                   run_left [KEYS];
		logic [mkdlp_pkg::LEVEL_W-1:0] lv;
		req_ch.valid      <= 1'b0;
		req_ch.mode       <= mkdlp_pkg::MODE_TICK;
		req_ch.key_levels <= '1;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= mkdlp_pkg::REG_DEBOUNCE;
		cfg_ch.data       <= '0;
		for (k = 0; k < KEYS; k++) begin
			pressed[k]  = 1'b0;
			run_left[k] = 0;
		end
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (i = 0; i < N_ROWS; i++) begin
			if (directed[i].kind == ROW_CFG)
				write_reg(directed[i].cfg_sel, directed[i].data);
			else
				offer_item(directed[i].mode, directed[i].levels, directed[i].typed,
					directed[i].want);
		end

		for (p = 0; p < N_PHASES; p++) begin
			write_reg(mkdlp_pkg::REG_DEBOUNCE, mkdlp_pkg::CFG_DATA_W'(phase_deb[p]));
			write_reg(mkdlp_pkg::REG_LONG, mkdlp_pkg::CFG_DATA_W'(phase_long[p]));
			for (n = 0; n < phase_items[p]; n++) begin
				if ($urandom_range(0, 4) == 0) begin
					offer_item(mkdlp_pkg::MODE_TAKE, mkdlp_pkg::LEVEL_W'($urandom), 1'b0,
						NO_EVENT);
				end else begin
					for (k = 0; k < KEYS; k++) begin
						if (run_left[k] == 0) begin
							pressed[k] = !pressed[k];
							if (pressed[k]) begin
								pick = $urandom_range(0, 9);
								// bounce, short press or a press around the long limit
								if (pick < 2)
									run = $urandom_range(1, 2);
								else if (pick < 6)
									run = deb_limit + 1 +
										$urandom_range(0, (long_limit < 20) ? long_limit : 20);
								else
									run = deb_limit + long_limit + $urandom_range(0, 2);
								run_left[k] = (run > 320) ? 320 : run;
							end else begin
								run_left[k] = $urandom_range(1, 6);
							end
						end
						run_left[k]--;
						lv[k] = !pressed[k];
					end
					offer_item(mkdlp_pkg::MODE_TICK, lv, 1'b0, NO_EVENT);
				end
			end
		end

		req_ch.valid <= 1'b0;
		while (awaited_events.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (faults == 0 && awaited_events.size() == 0)
			$display("tb_multi_key_debounce_long_press_unit: clean");
		else
			$display("tb_multi_key_debounce_long_press_unit: errors");
		$finish;
	end

	// response side, with one long hold-off to back the unit up
	initial begin
		int gap;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap(recv_calm);
			if (!squeezed && delivered >= 300) begin
				squeezed = 1'b1;
				gap      = 80;
			end
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		report_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			delivered++;
			if (awaited_events.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected event item: found=%0b key=%0d long=%0b",
						rsp_ch.event_valid, rsp_ch.event_key, rsp_ch.event_long);
			end else begin
				want = awaited_events.pop_front();
				if (want.found !== rsp_ch.event_valid || want.key !== rsp_ch.event_key ||
						want.is_long !== rsp_ch.event_long) begin
					faults++;
					if (faults <= 10)
						$display("event mismatch: expected found=%0b key=%0d long=%0b, %s%0b %s%0d %s%0b",
							want.found, want.key, want.is_long,
							"got found=", rsp_ch.event_valid,
							"key=", rsp_ch.event_key,
							"long=", rsp_ch.event_long);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_multi_key_debounce_long_press_unit: errors");
			$finish;
		end
	end

endmodule

/* multi_key_debounce_long_press_unit.f */
rtl/mkdlp_pkg.sv
rtl/mkdlp_if.sv
rtl/mkdlp_key_cell.sv
rtl/multi_key_debounce_long_press_unit.sv
bench/tb_multi_key_debounce_long_press_unit.sv
